>>> hw/rtl/sfdr_pkg.sv
// Shared constants, types and register indexes of the sensor frame deframer.
package sfdr_pkg;

  localparam int WinLen  = 16;
  localparam int SumLen  = 14;
  localparam int IdxW    = $clog2(WinLen);
  localparam int FillW   = $clog2(WinLen + 1);
  localparam int CfgIdxW = 4;
  localparam int CfgDatW = 16;
  localparam int AxisW   = 22;
  localparam int OpaW    = 18;
  localparam int OpbW    = 17;
  localparam int ProdW   = OpaW + OpbW;

  localparam logic signed [OpbW-1:0] CkMul    = 17'sd44111;
  localparam logic signed [OpbW-1:0] RotNum   = 17'sd46341;
  localparam logic signed [OpbW-1:0] ScaleNum = 17'sd125;

  localparam logic [7:0]  SyncReset   = 8'h50;
  localparam logic [15:0] CenterReset = 16'd2048;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SYNC_BYTE     = 4'd0,
    REG_CENTER_OFFSET = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    logic push;
    logic drop;
    logic clear;
  } win_cmd_t;

  typedef struct packed {
    logic acc_clr;
    logic acc_en;
    logic prod_en;
  } mul_cmd_t;

endpackage

>>> hw/rtl/sfdr_in_if.sv
// Input byte channel.
interface sfdr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/sfdr_out_if.sv
// Result channel carrying the checksum flag and the three axis values.
interface sfdr_out_if;
  import sfdr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    checksum_ok;
  logic signed [AxisW-1:0] axis_pitch;
  logic signed [AxisW-1:0] axis_lateral;
  logic signed [AxisW-1:0] axis_vertical;

  modport source (output valid, output checksum_ok, output axis_pitch,
                  output axis_lateral, output axis_vertical, input ready);
  modport sink   (input valid, input checksum_ok, input axis_pitch,
                  input axis_lateral, input axis_vertical, output ready);
endinterface

>>> hw/rtl/sfdr_cfg_if.sv
// Configuration write channel.
interface sfdr_cfg_if;
  import sfdr_pkg::*;

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/sfdr_window.sv
// Sixteen-byte sliding window with its fill count.
module sfdr_window (
  input  logic                         clk,
  input  logic                         rst,
  input  sfdr_pkg::win_cmd_t           cmd,
  input  logic [7:0]                   din,
  output logic [sfdr_pkg::WinLen-1:0][7:0] bytes,
  output logic                         full
);
  import sfdr_pkg::*;

  logic [FillW-1:0] fill;

  assign full = (fill == FillW'(WinLen));

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.clear) begin
      fill <= '0;
    end else if (cmd.push) begin
      if (!full) begin
        fill <= fill + 1'b1;
      end
    end else if (cmd.drop) begin
      if (fill != '0) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // A push into a full window drops the oldest word first.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (full) begin
        for (int i = 0; i < WinLen - 1; i++) begin
          bytes[i] <= bytes[i+1];
        end
        bytes[WinLen-1] <= din;
      end else begin
        bytes[fill[IdxW-1:0]] <= din;
      end
    end else if (cmd.drop) begin
      for (int i = 0; i < WinLen - 1; i++) begin
        bytes[i] <= bytes[i+1];
      end
      bytes[WinLen-1] <= '0;
    end
  end

endmodule

>>> hw/rtl/sfdr_mul.sv
// Shared signed multiplier with a registered product and a checksum accumulator.
module sfdr_mul (
  input  logic                                clk,
  input  sfdr_pkg::mul_cmd_t                  cmd,
  input  logic signed [sfdr_pkg::OpaW-1:0]    op_a,
  input  logic signed [sfdr_pkg::OpbW-1:0]    op_b,
  output logic signed [sfdr_pkg::ProdW-1:0]   prod,
  output logic [15:0]                         acc
);
  import sfdr_pkg::*;

  logic signed [ProdW-1:0] prod_c;

  assign prod_c = op_a * op_b;

  always_ff @(posedge clk) begin
    if (cmd.prod_en) begin
      prod <= prod_c;
    end
    // Only the low 16 bits of each checksum term matter, so the sum wraps.
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc + prod_c[15:0];
    end
  end

endmodule

>>> hw/rtl/sensor_frame_deframer_rotator_top.sv
// Sensor frame deframer: byte window, checksum test and axis rotation sequencer.
//
// Bytes arrive on in_ch and enter a 16-byte sliding window. When the window
// is full and its oldest byte equals the sync byte, the frame is checked and
// one word goes out on out_ch: checksum_ok = 1 with three scaled, rotated
// axis values, or checksum_ok = 0 with zero axes. Other bytes give no word.
// cfg writes the sync byte (index 0) and the center offset (index 1); other
// indexes are ignored. Write it only while the block is idle.
//
// One multiplier does all the work. A frame check multiplies and accumulates the
// first 14 window bytes for the checksum; a good frame then takes the five
// products of rotation and scaling. in_ch.ready is low while a byte is being
// processed.
//
// A result sits in an output register until taken. If the receiver still
// holds the previous word, the sequencer waits before loading the new one.
// Reset empties the window, drops any pending word and restores the
// register defaults (sync byte 0x50, center offset 2048).
module sensor_frame_deframer_rotator_top (
  input logic       clk,
  input logic       rst,
  sfdr_in_if.sink   in_ch,
  sfdr_out_if.source out_ch,
  sfdr_cfg_if.sink  cfg
);
  import sfdr_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TEST  = 6'b000010,
    S_SUM   = 6'b000100,
    S_CHECK = 6'b001000,
    S_MUL   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  logic [IdxW-1:0] cnt;

  logic [7:0]  sync_byte;
  logic [15:0] center_offset;

  win_cmd_t win_cmd;
  logic [WinLen-1:0][7:0] win;
  logic win_full;

  mul_cmd_t mul_cmd;
  logic signed [OpaW-1:0]  op_a;
  logic signed [OpbW-1:0]  op_b;
  logic signed [ProdW-1:0] prod;
  logic [15:0] acc;

  logic signed [16:0] ax_x, ax_y, ax_z;
  logic signed [OpaW-1:0] xz_diff, xz_sum;
  logic signed [OpaW-1:0] xr, zr;
  logic signed [ProdW-1:0] rot_round, scl_round;
  logic signed [OpaW-1:0]  rot_q;
  logic signed [AxisW-1:0] scl_q;
  logic [15:0] ck_fold, ck_word;
  logic ck_good;

  logic res_ok;
  logic signed [AxisW-1:0] res_pitch, res_lat, res_vert;
  logic out_load;

  sfdr_window u_window (
    .clk   (clk),
    .rst   (rst),
    .cmd   (win_cmd),
    .din   (in_ch.rx_byte),
    .bytes (win),
    .full  (win_full)
  );

  sfdr_mul u_mul (
    .clk  (clk),
    .cmd  (mul_cmd),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod),
    .acc  (acc)
  );

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte     <= SyncReset;
      center_offset <= CenterReset;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SYNC_BYTE:     sync_byte     <= cfg.data[7:0];
        REG_CENTER_OFFSET: center_offset <= cfg.data;
        default: ;
      endcase
    end
  end

  // Centered axes, taken straight from the window, which holds still meanwhile.
  assign ax_x = $signed({1'b0, win[9], win[8]}) - $signed({1'b0, center_offset});
  assign ax_y = $signed({1'b0, center_offset}) - $signed({1'b0, win[11], win[10]});
  assign ax_z = $signed({1'b0, center_offset}) - $signed({1'b0, win[13], win[12]});
  assign xz_diff = {ax_x[16], ax_x} - {ax_z[16], ax_z};
  assign xz_sum  = {ax_x[16], ax_x} + {ax_z[16], ax_z};

  // Truncation toward zero of the registered product by 65536 and by 8.
  assign rot_round = prod + (prod[ProdW-1] ? ProdW'(65535) : ProdW'(0));
  assign scl_round = prod + (prod[ProdW-1] ? ProdW'(7) : ProdW'(0));
  assign rot_q = rot_round[OpaW+15:16];
  assign scl_q = scl_round[AxisW+2:3];

  assign ck_fold = acc ^ {8'h00, acc[15:8]};
  assign ck_word = {win[15], win[14]};
  assign ck_good = (ck_fold == ck_word);

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state == S_SUM) begin
      op_a = $signed({{(OpaW-8){1'b0}}, win[cnt]});
      op_b = CkMul;
    end else if (state == S_MUL) begin
      case (cnt)
        4'd0: begin
          op_a = xz_diff;
          op_b = RotNum;
        end
        4'd1: begin
          op_a = xz_sum;
          op_b = RotNum;
        end
        4'd2: begin
          op_a = -xr;
          op_b = ScaleNum;
        end
        4'd3: begin
          op_a = {ax_y[16], ax_y};
          op_b = ScaleNum;
        end
        4'd4: begin
          op_a = -zr;
          op_b = ScaleNum;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_cmd.acc_clr = (state == S_TEST);
    mul_cmd.acc_en  = (state == S_SUM);
    mul_cmd.prod_en = (state == S_MUL);
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!out_ch.valid || out_ch.ready);

  always_comb begin
    win_cmd.push  = in_ch.valid && in_ch.ready;
    win_cmd.drop  = (state == S_CHECK) && !ck_good;
    win_cmd.clear = (state == S_MUL) && (cnt == 4'd5);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            state <= S_TEST;
          end
        end
        S_TEST: begin
          cnt <= '0;
          if (win_full && win[0] == sync_byte) begin
            state <= S_SUM;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SUM: begin
          cnt <= cnt + 1'b1;
          if (cnt == IdxW'(SumLen - 1)) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          cnt <= '0;
          if (ck_good) begin
            state <= S_MUL;
          end else begin
            state <= S_OUT;
          end
        end
        S_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == 4'd5) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result assembly; each product is captured from the product register in the step after it is formed.
  always_ff @(posedge clk) begin
    if (state == S_CHECK) begin
      res_ok    <= ck_good;
      res_pitch <= '0;
      res_lat   <= '0;
      res_vert  <= '0;
    end else if (state == S_MUL) begin
      case (cnt)
        4'd1: xr <= rot_q;
        4'd2: zr <= rot_q;
        4'd3: res_pitch <= scl_q;
        4'd4: res_lat <= scl_q;
        4'd5: res_vert <= scl_q;
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.checksum_ok   <= res_ok;
      out_ch.axis_pitch    <= res_pitch;
      out_ch.axis_lateral  <= res_lat;
      out_ch.axis_vertical <= res_vert;
    end
  end

endmodule

>>> dv/sfdr_tb_pkg.sv
// Frame type and frame checksum shared by the deframer stimulus and checker.
package sfdr_tb_pkg;
  import sfdr_pkg::*;

  // Byte i of a frame is element i, so a little-endian word at offset k is f[k+1:k].
  typedef logic [WinLen-1:0][7:0] frame_t;

  function automatic logic [15:0] frame_check_word(input frame_t f);
    logic [15:0] acc;
    logic [31:0] prod;
    int i;
    acc = '0;
    for (i = 0; i < SumLen; i++) begin
      prod = f[i] * CkMul;
      acc = acc + prod[15:0];
    end
    return acc ^ (acc >> 8);
  endfunction

endpackage

>>> dv/sfdr_checker.sv
// Checker for the deframer: tracks the byte window, predicts result words, compares them.
module sfdr_checker (
  input  logic clk,
  input  logic rst,
  sfdr_in_if   in_ch,
  sfdr_out_if  out_ch,
  sfdr_cfg_if  cfg,
  output int   errors,
  output int   words_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import sfdr_pkg::*;
  import sfdr_tb_pkg::*;

  localparam longint RotDiv   = 65536;
  localparam longint ScaleDiv = 8;

  typedef struct packed {
    logic                    ok;
    logic signed [AxisW-1:0] pitch;
    logic signed [AxisW-1:0] lateral;
    logic signed [AxisW-1:0] vertical;
  } axis_word_t;

  frame_t      win;
  int unsigned fill;
  logic [7:0]  sync_val;
  logic [15:0] center_val;
  axis_word_t  axis_words_due[$];

  // Pushes one byte into the window; returns 1 when the byte completes a frame check.
  function automatic bit deframe_byte(input logic [7:0] b, output axis_word_t res);
    longint x, y, z, xr, zr, p, l, v;
    res = '0;
    if (fill >= WinLen) begin
      win = win >> 8;
      fill = fill - 1;
    end
    win[fill] = b;
    fill = fill + 1;
    if (fill < WinLen || win[0] != sync_val) return 1'b0;
    if (frame_check_word(win) != win[15:14]) begin
      win = win >> 8;
      fill = fill - 1;
      return 1'b1;
    end
    x = win[9:8];
    x = x - center_val;
    y = center_val;
    y = y - win[11:10];
    z = center_val;
    z = z - win[13:12];
    xr = ((x - z) * RotNum) / RotDiv;
    zr = ((x + z) * RotNum) / RotDiv;
    p = (-xr * ScaleNum) / ScaleDiv;
    l = (y * ScaleNum) / ScaleDiv;
    v = (-zr * ScaleNum) / ScaleDiv;
    res.ok = 1'b1;
    res.pitch = p[AxisW-1:0];
    res.lateral = l[AxisW-1:0];
    res.vertical = v[AxisW-1:0];
    win = '0;
    fill = 0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    axis_word_t got, want;
    int n;
    n = 0;
    if (rst) begin
      win = '0;
      fill = 0;
      sync_val = SyncReset;
      center_val = CenterReset;
      axis_words_due.delete();
      errors <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_SYNC_BYTE) sync_val = cfg.data[7:0];
        else if (cfg.index == REG_CENTER_OFFSET) center_val = cfg.data;
      end
      if (in_ch.valid && in_ch.ready) begin
        if (deframe_byte(in_ch.rx_byte, want)) axis_words_due.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.checksum_ok, out_ch.axis_pitch, out_ch.axis_lateral,
               out_ch.axis_vertical};
        if (axis_words_due.size() == 0) begin
          $error("result word with no frame check pending");
          n++;
        end else begin
          want = axis_words_due.pop_front();
          if (got.ok !== want.ok) begin
            $error("checksum_ok: expected %0d, got %0d", want.ok, got.ok);
            n++;
          end
          if (got.pitch !== want.pitch) begin
            $error("axis_pitch: expected %0d, got %0d", want.pitch, got.pitch);
            n++;
          end
          if (got.lateral !== want.lateral) begin
            $error("axis_lateral: expected %0d, got %0d", want.lateral, got.lateral);
            n++;
          end
          if (got.vertical !== want.vertical) begin
            $error("axis_vertical: expected %0d, got %0d", want.vertical, got.vertical);
            n++;
          end
        end
      end
      errors <= errors + n;
    end
    words_due <= axis_words_due.size();
  end

endmodule

>>> dv/tb.sv
// Testbench top: clock, reset, byte and register stimulus, result backpressure, verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfdr_pkg::*;
  import sfdr_tb_pkg::*;

  localparam int CycleLimit   = 2_000_000;
  localparam int Phases       = 8;
  localparam int PhaseBytes   = 118;
  localparam int SettleCycles = 40;

  logic        clk = 1'b0;
  logic        rst;
  int          errors;
  int          words_due;
  int          send_calm = 0;
  int          take_calm = 0;
  logic [7:0]  cur_sync;
  logic [15:0] cur_center;

  sfdr_in_if  in_ch ();
  sfdr_out_if out_ch ();
  sfdr_cfg_if cfg ();

  sensor_frame_deframer_rotator_top uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  sfdr_checker chk (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg       (cfg),
    .errors    (errors),
    .words_due (words_due)
  );

  always #4 clk = ~clk;

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 150);
  endfunction

  function automatic logic [15:0] axis_raw();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return cur_center;
      3: return cur_center ^ 16'(1 << $urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic frame_t make_frame();
    frame_t f;
    int i;
    f = '0;
    f[0] = cur_sync;
    for (i = 1; i < 8; i++) f[i] = 8'($urandom);
    f[9:8] = axis_raw();
    f[11:10] = axis_raw();
    f[13:12] = axis_raw();
    f[15:14] = frame_check_word(f);
    return f;
  endfunction

  // Leaves valid high after the word is taken; the next call or quiesce() decides.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_len(send_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_frame(input frame_t f, input int count);
    int i;
    for (i = 0; i < count; i++) send_byte(f[i]);
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // The sync byte gets junk in the upper data bits, which the block must mask.
  task automatic apply_setting(input logic [7:0] s, input logic [15:0] c);
    if ($urandom_range(0, 1)) begin
      write_reg(4'($urandom_range(int'(REG_CENTER_OFFSET) + 1, (1 << CfgIdxW) - 1)),
                16'($urandom));
    end
    write_reg(REG_SYNC_BYTE, {8'($urandom), s});
    write_reg(REG_CENTER_OFFSET, c);
    cur_sync = s;
    cur_center = c;
  endtask

  task automatic random_phase();
    frame_t f;
    int sent, kind, n, pos, i;
    sent = 0;
    while (sent < PhaseBytes) begin
      f = make_frame();
      n = WinLen;
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        // Corrupt one bit after the sync byte so the checksum fails.
        pos = $urandom_range(1, WinLen - 1);
        f[pos] = f[pos] ^ 8'(1 << $urandom_range(0, 7));
      end else if (kind < 22) begin
        n = $urandom_range(1, WinLen - 1);
      end else if (kind < 35) begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) f[i] = 8'($urandom);
      end
      send_frame(f, n);
      sent += n;
    end
  endtask

  initial begin : result_taker
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = idle_len(take_calm);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk);
    $display("tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    frame_t g;
    int p;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.rx_byte <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= '0;
    cfg.data <= '0;
    cur_sync = SyncReset;
    cur_center = CenterReset;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Two junk bytes become the non-sync oldest bytes of the first full windows, then a
    // stray sync byte ahead of a good frame forces a checksum mismatch before the good check.
    g = make_frame();
    g[1] = 8'hFF;
    g[2] = 8'h00;
    g[9:8] = 16'hFFFF;
    g[11:10] = 16'h0000;
    g[13:12] = 16'hFFFF;
    g[15:14] = frame_check_word(g);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(cur_sync);
    send_frame(g, WinLen);
    quiesce();

    for (p = 0; p < Phases; p++) begin
      case (p)
        0: ;
        1: apply_setting(8'h00, 16'h0000);
        2: apply_setting(8'hFF, 16'hFFFF);
        3: apply_setting(SyncReset, CenterReset);
        default: apply_setting(8'($urandom), 16'($urandom));
      endcase
      random_phase();
      quiesce();
    end

    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/sfdr_pkg.sv
hw/rtl/sfdr_in_if.sv
hw/rtl/sfdr_out_if.sv
hw/rtl/sfdr_cfg_if.sv
hw/rtl/sfdr_window.sv
hw/rtl/sfdr_mul.sv
hw/rtl/sensor_frame_deframer_rotator_top.sv
dv/sfdr_tb_pkg.sv
dv/sfdr_checker.sv
dv/tb.sv
